[src/sld_pkg.sv]
// Shared types and constants for the string literal destringizer.
package sld_pkg;

    localparam int MAX_DELIM  = 16;
    localparam int HOLD_DEPTH = MAX_DELIM + 1;
    localparam int DELIM_W    = $clog2(MAX_DELIM + 1);
    localparam int FILL_W     = $clog2(HOLD_DEPTH + 1);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_UPPER_U = 8'h55;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_8       = 8'h38;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // One queue entry: one or two output bytes; last tags the final byte.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic       two;
        logic       last;
    } t_cmd;

endpackage

[src/sld_front.sv]
// Front end: parses the literal spelling and queues the bytes to emit.
module sld_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output sld_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        PH_PREFIX    = 7'b0000001,
        PH_AFTER_U   = 7'b0000010,
        PH_START     = 7'b0000100,
        PH_RAW_OPEN  = 7'b0001000,
        PH_RAW_DELIM = 7'b0010000,
        PH_RAW_BODY  = 7'b0100000,
        PH_ORD_BODY  = 7'b1000000
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic                         r_pend, n_pend;
    logic [sld_pkg::DELIM_W-1:0]  r_delim, n_delim;
    logic [sld_pkg::FILL_W-1:0]   r_fill, n_fill;
    logic [7:0]                   r_hold [sld_pkg::HOLD_DEPTH];

    logic acc;
    logic do_open;
    logic hold_shift;

    assign o_ready = ~i_full;
    assign acc     = i_valid & ~i_full;

    always_comb begin
        n_phase    = r_phase;
        n_pend     = r_pend;
        n_delim    = r_delim;
        n_fill     = r_fill;
        o_push     = 1'b0;
        o_cmd      = '{b0: sld_pkg::CH_SPACE, b1: sld_pkg::CH_NL, two: 1'b0, last: 1'b0};
        do_open    = 1'b0;
        hold_shift = 1'b0;
        if (acc) begin
            if (i_last) begin
                o_push   = 1'b1;
                o_cmd.last = 1'b1;
                if (r_phase == PH_ORD_BODY && r_pend) begin
                    o_cmd.b0  = sld_pkg::CH_BSLASH;
                    o_cmd.two = 1'b1;
                end else begin
                    o_cmd.b0 = sld_pkg::CH_NL;
                end
                n_phase = PH_PREFIX;
                n_pend  = 1'b0;
                n_delim = '0;
                n_fill  = '0;
            end else begin
                case (r_phase)
                    PH_AFTER_U: begin
                        if (i_byte == sld_pkg::CH_8) n_phase = PH_START;
                        else do_open = 1'b1;
                    end
                    PH_START: begin
                        do_open = 1'b1;
                    end
                    PH_RAW_OPEN: begin
                        n_phase = PH_RAW_DELIM;
                    end
                    PH_RAW_DELIM: begin
                        if (i_byte == sld_pkg::CH_LPAREN) begin
                            o_push  = 1'b1;
                            n_fill  = '0;
                            n_phase = PH_RAW_BODY;
                        end else if (r_delim < sld_pkg::DELIM_W'(sld_pkg::MAX_DELIM)) begin
                            n_delim = r_delim + 1'b1;
                        end
                    end
                    PH_RAW_BODY: begin
                        hold_shift = 1'b1;
                        // line is full once it holds delim+1 bytes; oldest one leaves
                        if (r_fill > sld_pkg::FILL_W'(r_delim)) begin
                            o_push   = 1'b1;
                            o_cmd.b0 = r_hold[r_delim];
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    PH_ORD_BODY: begin
                        if (r_pend) begin
                            n_pend = 1'b0;
                            o_push = 1'b1;
                            if (!(i_byte inside {sld_pkg::CH_BSLASH, sld_pkg::CH_QUOTE})) begin
                                o_cmd.b0  = sld_pkg::CH_BSLASH;
                                o_cmd.b1  = i_byte;
                                o_cmd.two = 1'b1;
                            end else begin
                                o_cmd.b0 = i_byte;
                            end
                        end else if (i_byte == sld_pkg::CH_BSLASH) begin
                            n_pend = 1'b1;
                        end else begin
                            o_push   = 1'b1;
                            o_cmd.b0 = i_byte;
                        end
                    end
                    default: begin
                        if (i_byte inside {sld_pkg::CH_L, sld_pkg::CH_UPPER_U})
                            n_phase = PH_START;
                        else if (i_byte == sld_pkg::CH_LOWER_U)
                            n_phase = PH_AFTER_U;
                        else
                            do_open = 1'b1;
                    end
                endcase
                if (do_open) begin
                    if (i_byte == sld_pkg::CH_R) begin
                        n_phase = PH_RAW_OPEN;
                    end else begin
                        o_push  = 1'b1;
                        n_phase = PH_ORD_BODY;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_pend  <= 1'b0;
            r_delim <= '0;
            r_fill  <= '0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_delim <= n_delim;
            r_fill  <= n_fill;
        end
    end

    // holdback line, newest byte at index 0
    always_ff @(posedge i_clk) begin
        if (hold_shift) begin
            r_hold[0] <= i_byte;
            for (int i = 1; i < sld_pkg::HOLD_DEPTH; i++) r_hold[i] <= r_hold[i-1];
        end
    end

endmodule

[src/sld_queue.sv]
// Small FIFO of output commands between the parser and the output stage.
module sld_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sld_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output sld_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    sld_pkg::t_cmd               r_mem [sld_pkg::QDEPTH];
    logic [sld_pkg::QPTR_W-1:0]  r_wptr, r_rptr;
    logic [sld_pkg::QCNT_W-1:0]  r_cnt, n_cnt;
    logic                        do_push, do_pop;

    assign o_full  = (r_cnt == sld_pkg::QCNT_W'(sld_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push & ~do_pop) n_cnt = r_cnt + 1'b1;
        else if (~do_push & do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_cmd;
    end

endmodule

[src/sld_back.sv]
// Back end: splits queued commands into single output beats.
module sld_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sld_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [7:0]    o_byte,
    output logic          o_last
);

    logic       r_valid;
    logic       r_half;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       final_beat;

    assign load       = i_valid & (~r_valid | i_tready);
    assign final_beat = ~i_cmd.two | r_half;
    assign o_pop      = load & final_beat;
    assign o_tvalid   = r_valid;
    assign o_byte     = r_byte;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= ~final_beat;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= r_half ? i_cmd.b1 : i_cmd.b0;
            r_last <= i_cmd.last & final_beat;
        end
    end

endmodule

[src/string_literal_destringizer.sv]
// Top level of the C string literal destringizer.
// Feed the bytes of one string literal token on the slave stream, tlast on the
// closing quote; the master stream carries the destringized text, tlast on the
// closing newline. One input beat is taken per cycle while the 4-entry command
// queue has room; a byte yields zero, one or two output beats, and the output
// register sends one beat per cycle while i_m_tready is high, so bytes that
// expand to two beats (escapes kept as written, a backslash before the closing
// quote) run at half rate on the output side. Output bytes pass through the
// command queue, then the output register. Raw literals hold back delimiter
// length plus one body bytes in a shift line; delimiters over 16 count as 16.
module string_literal_destringizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);

    logic          push, full, q_valid, pop;
    sld_pkg::t_cmd push_cmd, head_cmd;

    sld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    sld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    sld_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_byte   (o_m_tdata),
        .o_last   (o_m_tlast)
    );

endmodule
